// ===== src/npr_pkg.sv =====
// Package for the plane rotation chain: payload structs, configuration
// struct, register indexes and the plane order table.
// No dependencies.
package npr_pkg;

	localparam int AXES    = 4;
	localparam int NROT    = 6;
	localparam int COORD_W = 32;
	localparam int COEF_W  = 16;
	localparam int REG_W   = 32;
	localparam int IDX_W   = 3;
	localparam int FRAC_W  = 14;
	localparam int PROD_W  = COORD_W + COEF_W;

	// reset value of each rotation register: cos 1.0, sin 0.0 in Q2.14
	localparam logic [REG_W-1:0] ROT_RESET = 32'h4000_0000;

	typedef enum logic [IDX_W-1:0] {
		REG_ROT_1_0    = 3'd0,
		REG_ROT_2_0    = 3'd1,
		REG_ROT_2_1    = 3'd2,
		REG_ROT_3_0    = 3'd3,
		REG_ROT_3_1    = 3'd4,
		REG_ROT_3_2    = 3'd5,
		REG_PLANE_MODE = 3'd6
	} reg_idx_t;

	// plane k rotates axes (PLANE_I[k], PLANE_J[k]) using register k
	localparam logic [1:0] PLANE_I [NROT] = '{2'd1, 2'd2, 2'd2, 2'd3, 2'd3, 2'd3};
	localparam logic [1:0] PLANE_J [NROT] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd1, 2'd2};

	typedef logic [AXES-1:0][COORD_W-1:0] vec_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] coord_0;
		logic signed [COORD_W-1:0] coord_1;
		logic signed [COORD_W-1:0] coord_2;
		logic signed [COORD_W-1:0] coord_3;
	} point_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rotated_0;
		logic signed [COORD_W-1:0] rotated_1;
		logic signed [COORD_W-1:0] rotated_2;
		logic signed [COORD_W-1:0] rotated_3;
	} point_out_t;

	typedef struct packed {
		logic [NROT-1:0][REG_W-1:0] rot;
		logic                       plane_mode;
	} cfg_t;

endpackage

// ===== src/npr_cfg.sv =====
// Configuration registers of the plane rotation chain: six cos/sin words
// and the plane mode bit. Depends on npr_pkg.
module npr_cfg import npr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data,
	output cfg_t             cfg
);

	logic [NROT-1:0][REG_W-1:0] rot_q;
	logic                       plane_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NROT; k++) rot_q[k] <= ROT_RESET;
			plane_mode_q <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROT_1_0:    rot_q[0] <= cfg_data;
				REG_ROT_2_0:    rot_q[1] <= cfg_data;
				REG_ROT_2_1:    rot_q[2] <= cfg_data;
				REG_ROT_3_0:    rot_q[3] <= cfg_data;
				REG_ROT_3_1:    rot_q[4] <= cfg_data;
				REG_ROT_3_2:    rot_q[5] <= cfg_data;
				REG_PLANE_MODE: plane_mode_q <= cfg_data[0];
				default: ;  // unused index, write dropped
			endcase
		end
	end

	assign cfg.rot        = rot_q;
	assign cfg.plane_mode = plane_mode_q;

endmodule

// ===== src/npr_cell.sv =====
// One plane rotation cell: products in the first stage, sum, rounding and
// saturation in the second. Carries the whole point. Depends on npr_pkg.
module npr_cell import npr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  vec_t             in_vec,
	input  logic [1:0]       plane_i,
	input  logic [1:0]       plane_j,
	input  logic             enable,
	input  logic [REG_W-1:0] coef,
	output logic             out_valid,
	output vec_t             out_vec
);

	localparam int SUM_W = PROD_W + 1;
	localparam int SHR_W = SUM_W - FRAC_W;

	function automatic logic [COORD_W-1:0] round_sat(input logic signed [SUM_W-1:0] acc);
		logic signed [SUM_W-1:0] biased;
		logic signed [SHR_W-1:0] shr;
		logic [COORD_W-1:0]      res;
		biased = acc + SUM_W'(signed'(1 << (FRAC_W - 1)));
		shr    = biased[SUM_W-1:FRAC_W];
		if (shr > SHR_W'(signed'({1'b0, {(COORD_W-1){1'b1}}})))
			res = {1'b0, {(COORD_W-1){1'b1}}};
		else if (shr < -SHR_W'(signed'({1'b0, 1'b1, {(COORD_W-1){1'b0}}})))
			res = {1'b1, {(COORD_W-1){1'b0}}};
		else
			res = shr[COORD_W-1:0];
		return res;
	endfunction

	logic signed [COORD_W-1:0] xi, xj;
	logic signed [COEF_W-1:0]  c, s;

	assign xi = signed'(in_vec[plane_i]);
	assign xj = signed'(in_vec[plane_j]);
	assign c  = signed'(coef[REG_W-1:COEF_W]);
	assign s  = signed'(coef[COEF_W-1:0]);

	logic                     valid_s1;
	logic                     en_s1;
	vec_t                     vec_s1;
	logic signed [PROD_W-1:0] p_ic_s1, p_js_s1, p_jc_s1, p_is_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		en_s1   <= enable;
		vec_s1  <= in_vec;
		p_ic_s1 <= PROD_W'(xi) * PROD_W'(c);
		p_js_s1 <= PROD_W'(xj) * PROD_W'(s);
		p_jc_s1 <= PROD_W'(xj) * PROD_W'(c);
		p_is_s1 <= PROD_W'(xi) * PROD_W'(s);
	end

	logic signed [SUM_W-1:0] acc_i, acc_j;
	vec_t                    next_vec;

	always_comb begin
		acc_i    = SUM_W'(p_ic_s1) - SUM_W'(p_js_s1);
		acc_j    = SUM_W'(p_jc_s1) + SUM_W'(p_is_s1);
		next_vec = vec_s1;
		if (en_s1) begin
			// new x_j uses the old x_i, both taken from the stage 1 products
			next_vec[plane_i] = round_sat(acc_i);
			next_vec[plane_j] = round_sat(acc_j);
		end
	end

	logic valid_s2;
	vec_t vec_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s2 <= 1'b0;
		else         valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		vec_s2 <= next_vec;
	end

	assign out_valid = valid_s2;
	assign out_vec   = vec_s2;

endmodule

// ===== src/nd_plane_rotation_chain.sv =====
// Top level of the plane rotation chain: input register, configuration
// registers and a row of rotation cells. Depends on npr_pkg, npr_cfg, npr_cell.
//
//  channel   handshake          payload                  notes
//  ------    ---------------    ---------------------    ----------------------
//  input     start & !busy      point   (point_in_t)     busy is never raised
//  result    done strobe        result  (point_out_t)    one cycle, no stall
//  config    cfg_we             cfg_index, cfg_data      index 7 ignored
//
// One item enters every cycle; each item passes the input register and then two
// stages per cell on its way to the output (NPLANES = DIMS*(DIMS-1)/2 cells).
// The chain has no back-pressure: the receiver takes each result as it appears.
// Reset clears the valid chain and loads cos 1.0 / sin 0.0 and plane mode 0.
module nd_plane_rotation_chain import npr_pkg::*; #(
	parameter int DIMS = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  point_in_t        point,
	output logic             done,
	output point_out_t       result,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [REG_W-1:0] cfg_data
);

	localparam int NPLANES = DIMS * (DIMS - 1) / 2;

	cfg_t cfg;

	npr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	assign busy = 1'b0;

	logic valid_s0;
	vec_t vec_s0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s0 <= 1'b0;
		else         valid_s0 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		vec_s0[0] <= point.coord_0;
		vec_s0[1] <= point.coord_1;
		vec_s0[2] <= point.coord_2;
		vec_s0[3] <= point.coord_3;
	end

	logic chain_vld [NPLANES+1];
	vec_t chain_vec [NPLANES+1];

	assign chain_vld[0] = valid_s0;
	assign chain_vec[0] = vec_s0;

	for (genvar k = 0; k < NPLANES; k++) begin : g_cell
		logic en;
		// plane mode 1 keeps only the planes that pair axis 1 with a higher axis
		assign en = cfg.plane_mode ? (PLANE_J[k] == 2'd1) : 1'b1;

		npr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (chain_vld[k]),
			.in_vec    (chain_vec[k]),
			.plane_i   (PLANE_I[k]),
			.plane_j   (PLANE_J[k]),
			.enable    (en),
			.coef      (cfg.rot[k]),
			.out_valid (chain_vld[k+1]),
			.out_vec   (chain_vec[k+1])
		);
	end

	assign done             = chain_vld[NPLANES];
	assign result.rotated_0 = signed'(chain_vec[NPLANES][0]);
	assign result.rotated_1 = signed'(chain_vec[NPLANES][1]);
	assign result.rotated_2 = signed'(chain_vec[NPLANES][2]);
	assign result.rotated_3 = signed'(chain_vec[NPLANES][3]);

endmodule

// ===== tb/tb_nd_plane_rotation_chain.sv =====
// Testbench for nd_plane_rotation_chain: drives points and register writes, predicts
// each rotated point and checks every done strobe against it.
// Depends on npr_pkg and the block itself.
`timescale 1ns / 100ps

module tb_nd_plane_rotation_chain;
	import npr_pkg::*;

	localparam int LATENCY = 1 + 2 * NROT;
	localparam int GAP_MAX = 12;
	localparam logic [IDX_W-1:0] IDX_UNUSED = 3'd7;
	localparam longint COORD_MAX = 64'sd2147483647;
	localparam longint COORD_MIN = -64'sd2147483648;
	localparam logic [COORD_W-1:0] C_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] C_MIN = 32'h8000_0000;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	point_in_t        point;
	logic             done;
	point_out_t       result;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [REG_W-1:0] cfg_data;

	// register copies held by the predictor, and the values the next load writes
	logic [REG_W-1:0] rot_model [NROT];
	logic             mode_model;
	logic [REG_W-1:0] rot_wanted [NROT];
	logic [REG_W-1:0] mode_word_wanted;

	point_out_t pending_rotations [$];
	int         mismatch_count;
	int         gap_pct;

	nd_plane_rotation_chain u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.point     (point),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// round to nearest with ties up, then clamp to the 32-bit coordinate range
	function automatic logic [COORD_W-1:0] round_clamp(input longint acc);
		longint q;
		q = (acc + 64'sd8192) >>> FRAC_W;
		if (q > COORD_MAX)
			q = COORD_MAX;
		if (q < COORD_MIN)
			q = COORD_MIN;
		return q[COORD_W-1:0];
	endfunction

	function automatic point_out_t rotate_point(input point_in_t p);
		longint     x [AXES];
		longint     c, s, xi, xj;
		int         k;
		point_out_t r;
		x[0] = p.coord_0;
		x[1] = p.coord_1;
		x[2] = p.coord_2;
		x[3] = p.coord_3;
		for (k = 0; k < NROT; k++) begin
			// axis-1 mode keeps only the planes (2,1) and (3,1)
			if (!mode_model || PLANE_J[k] == 2'd1) begin
				c = $signed(rot_model[k][31:16]);
				s = $signed(rot_model[k][15:0]);
				xi = x[PLANE_I[k]];
				xj = x[PLANE_J[k]];
				x[PLANE_I[k]] = $signed(round_clamp(xi * c - xj * s));
				x[PLANE_J[k]] = $signed(round_clamp(xj * c + xi * s));
			end
		end
		r = {x[0][31:0], x[1][31:0], x[2][31:0], x[3][31:0]};
		return r;
	endfunction

	function automatic logic [COORD_W-1:0] pick_coord();
		logic [COORD_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = C_MAX;
			1: v = C_MIN;
			2, 3, 4: v = $urandom_range(0, 1 << 20) - (1 << 19);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	function automatic logic [REG_W-1:0] pick_rot_word();
		logic [REG_W-1:0] w;
		case ($urandom_range(0, 4))
			0, 1: w = $urandom;
			2: w = {16'($urandom_range(0, 32768) - 16384), 16'($urandom_range(0, 32768) - 16384)};
			3: w = {($urandom_range(0, 1) ? 16'h7FFF : 16'h8000),
			        ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)};
			default: w = ROT_RESET;
		endcase
		return w;
	endfunction

	// one item: optional idle burst, then hold start until the edge that takes it
	task automatic send_point(input point_in_t p);
		if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, GAP_MAX)) @(posedge clk);
		end
		start <= 1'b1;
		point <= p;
		do @(posedge clk); while (busy);
		pending_rotations.push_back(rotate_point(p));
	endtask

	// waits for the chain to empty, then writes all registers from the wanted copies
	task automatic load_config(input bit poke_unused);
		int k;
		start <= 1'b0;
		while (pending_rotations.size() != 0)
			@(posedge clk);
		for (k = 0; k < NROT; k++) begin
			cfg_we <= 1'b1;
			cfg_index <= reg_idx_t'(REG_ROT_1_0 + k);
			cfg_data <= rot_wanted[k];
			@(posedge clk);
			rot_model[k] = rot_wanted[k];
		end
		cfg_we <= 1'b1;
		cfg_index <= REG_PLANE_MODE;
		cfg_data <= mode_word_wanted;
		@(posedge clk);
		mode_model = mode_word_wanted[0];
		if (poke_unused) begin
			cfg_we <= 1'b1;
			cfg_index <= IDX_UNUSED;
			cfg_data <= $urandom;
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	task automatic set_all_rot(input logic [REG_W-1:0] w, input logic [REG_W-1:0] mode_word);
		int k;
		for (k = 0; k < NROT; k++)
			rot_wanted[k] = w;
		mode_word_wanted = mode_word;
	endtask

	task automatic test_identity_at_reset();
		send_point({32'd0, 32'd0, 32'd0, 32'd0});
		send_point({C_MAX, C_MAX, C_MAX, C_MAX});
		send_point({C_MIN, C_MIN, C_MIN, C_MIN});
		send_point({C_MAX, C_MIN, 32'd1, 32'hFFFF_FFFF});
		send_point({32'h0001_0000, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA});
	endtask

	task automatic test_saturation_and_rounding();
		// near +2 and -2 on both terms drives steps into the clamp
		set_all_rot(32'h7FFF_7FFF, 32'd0);
		load_config(1'b0);
		send_point({C_MAX, C_MAX, C_MIN, C_MIN});
		send_point({C_MIN, C_MAX, C_MIN, C_MAX});
		set_all_rot(32'h8000_8000, 32'd0);
		load_config(1'b0);
		send_point({C_MAX, C_MIN, C_MAX, C_MIN});
		send_point({C_MIN, C_MIN, C_MIN, C_MIN});
		// smallest negative cosine and sine
		set_all_rot(32'hFFFF_FFFF, 32'd0);
		load_config(1'b0);
		send_point({C_MAX, 32'd12345, 32'hFFFF_0000, C_MIN});
		// cosine one LSB, sine zero: exact half-LSB ties
		set_all_rot(32'h0001_0000, 32'd0);
		load_config(1'b0);
		send_point({32'h0000_2000, 32'hFFFF_E000, 32'h0000_6000, 32'hFFFF_A000});
		set_all_rot(32'h0000_0000, 32'd0);
		load_config(1'b0);
		send_point({C_MAX, C_MIN, C_MAX, C_MIN});
	endtask

	task automatic test_axis1_planes_only();
		int k;
		for (k = 0; k < NROT; k++)
			rot_wanted[k] = pick_rot_word();
		// only bit 0 of the mode word counts
		mode_word_wanted = 32'hFFFF_FFFF;
		load_config(1'b0);
		send_point({C_MAX, C_MIN, C_MAX, C_MIN});
		send_point({pick_coord(), pick_coord(), pick_coord(), pick_coord()});
		send_point({pick_coord(), pick_coord(), pick_coord(), pick_coord()});
		mode_word_wanted = 32'hFFFF_FFFE;
		load_config(1'b0);
		send_point({pick_coord(), pick_coord(), pick_coord(), pick_coord()});
	endtask

	task automatic test_unused_register_index();
		set_all_rot(32'h2D41_2D41, 32'd0);
		load_config(1'b1);
		send_point({C_MAX, 32'd0, C_MIN, 32'h0001_0000});
		send_point({pick_coord(), pick_coord(), pick_coord(), pick_coord()});
	endtask

	task automatic test_random_points();
		int phase, n, k;
		for (phase = 0; phase < 8; phase++) begin
			for (k = 0; k < NROT; k++)
				rot_wanted[k] = pick_rot_word();
			mode_word_wanted = ($urandom & 32'hFFFF_FFFE) | 32'(phase % 3 == 2);
			load_config(phase % 4 == 1);
			case (phase)
				0, 3: gap_pct = 50;
				2: gap_pct = 0;
				7: gap_pct = 0;
				default: gap_pct = 12;
			endcase
			for (n = 0; n < 200; n++)
				send_point({pick_coord(), pick_coord(), pick_coord(), pick_coord()});
		end
	endtask

	always @(posedge clk) begin
		logic [4*COORD_W-1:0] got_v, exp_v;
		int f;
		if (arst_n && done) begin
			if (pending_rotations.size() == 0) begin
				$error("done with no item outstanding: %h", result);
				mismatch_count++;
			end else begin
				got_v = result;
				exp_v = pending_rotations.pop_front();
				for (f = 0; f < AXES; f++) begin
					if (got_v[(AXES-1-f)*COORD_W +: COORD_W]
					    !== exp_v[(AXES-1-f)*COORD_W +: COORD_W]) begin
						$error("rotated_%0d: expected %0d, got %0d", f,
						       $signed(exp_v[(AXES-1-f)*COORD_W +: COORD_W]),
						       $signed(got_v[(AXES-1-f)*COORD_W +: COORD_W]));
						mismatch_count++;
					end
				end
			end
		end
	end

	initial begin
		int k, waited;
		mismatch_count = 0;
		gap_pct = 0;
		for (k = 0; k < NROT; k++)
			rot_model[k] = ROT_RESET;
		mode_model = 1'b0;
		arst_n <= 1'b0;
		start <= 1'b0;
		point <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_identity_at_reset();
		test_saturation_and_rounding();
		test_axis1_planes_only();
		test_unused_register_index();
		test_random_points();

		start <= 1'b0;
		waited = 0;
		while (pending_rotations.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		if (pending_rotations.size() != 0) begin
			$error("%0d items never came out", pending_rotations.size());
			mismatch_count++;
		end
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
